// ===== hw/rtl/point_to_grid_reducer_macros.svh =====
// Assertion macros used by the checker of the point to grid reducer.
`ifndef POINT_TO_GRID_REDUCER_MACROS_SVH
`define POINT_TO_GRID_REDUCER_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define PTG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("point_to_grid_reducer assertion failed");

// Clocked assertion that is also checked while reset is high.
`define PTG_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("point_to_grid_reducer assertion failed");

`endif

// ===== hw/rtl/ptg_pkg.sv =====
// Types, constants and codes of the point to grid reducer.
`timescale 1ns / 1ps
package ptg_pkg;

  localparam int MAX_COLS = 256;
  localparam int MAX_ROWS = 256;
  localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CELLS    = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W   = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int DIM_W    = 9;
  localparam int CNT_W    = 32;
  localparam int VAL_W    = 48;
  localparam int CFG_IDX_W = 4;

  localparam logic [2:0] MODE_COUNT = 3'd0;
  localparam logic [2:0] MODE_SUM   = 3'd1;
  localparam logic [2:0] MODE_MEAN  = 3'd2;
  localparam logic [2:0] MODE_MIN   = 3'd3;
  localparam logic [2:0] MODE_MAX   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_PIXEL_X = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_PIXEL_Y = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND  = 4'd7;

  localparam logic signed [VAL_W-1:0] SUM_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] SUM_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    logic               kind;
    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;
    logic               coord_bad;
    logic signed [31:0] value;
    logic               value_missing;
    logic [7:0]         read_row;
    logic [7:0]         read_col;
  } in_item_t;

  typedef struct packed {
    logic                    point_taken;
    logic [15:0]             cell_index;
    logic signed [VAL_W-1:0] cell_value;
    logic                    cell_touched;
  } out_item_t;

endpackage

// ===== hw/rtl/point_to_grid_reducer.sv =====
// Top level of the point to grid reducer: cell stores, mapping pipeline and mean divider.
// Each point or read walks the sequencer states from acceptance to its registered result;
// a mean read of a touched cell also passes the divider for its 48 divider steps.
// The sequencer handles one item at a time and takes no new item before the last result
// is loaded into the result register; a stalled result holds the next item off.
// Reset: synchronous; afterwards a clearing pass over all 65536 cells zeroes both stores
// while no item is accepted; configuration writes are taken throughout.
`timescale 1ns / 1ps
module point_to_grid_reducer
  import ptg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  in_item_t             item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output out_item_t            result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data
);

  // Sequencer states. Each item walks IDLE, MUL, MAP, ADDR, UPD and OUT; a mean
  // read of a touched cell detours through DIV.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_MAP   = 3'd3;
  localparam logic [2:0] S_ADDR  = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state;

  // Configuration registers.
  logic [DIM_W-1:0]        grid_width, grid_height;
  logic signed [31:0]      origin_x, origin_y, inv_pixel_x, inv_pixel_y;
  logic [2:0]              mode;
  logic signed [VAL_W-1:0] background;

  logic [DIM_W-1:0] eff_w, eff_h;
  assign eff_w = (grid_width > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : grid_width;
  assign eff_h = (grid_height > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : grid_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= DIM_W'(256);
      grid_height <= DIM_W'(256);
      origin_x    <= '0;
      origin_y    <= '0;
      inv_pixel_x <= 32'sd65536;
      inv_pixel_y <= -32'sd65536;
      mode        <= MODE_COUNT;
      background  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  grid_width  <= cfg_data[DIM_W-1:0];
        CFG_GRID_HEIGHT: grid_height <= cfg_data[DIM_W-1:0];
        CFG_ORIGIN_X:    origin_x    <= cfg_data[31:0];
        CFG_ORIGIN_Y:    origin_y    <= cfg_data[31:0];
        CFG_INV_PIXEL_X: inv_pixel_x <= cfg_data[31:0];
        CFG_INV_PIXEL_Y: inv_pixel_y <= cfg_data[31:0];
        CFG_MODE:        mode        <= cfg_data[2:0];
        CFG_BACKGROUND:  background  <= cfg_data;
        default: ;
      endcase
    end
  end

  // The two cell stores share one address sequence: a single read port with
  // registered data and a single write port. Items are handled one at a time,
  // so a write back always lands before the next read of any cell.
  logic [CNT_W-1:0] count_mem [CELLS];
  logic [VAL_W-1:0] value_mem [CELLS];

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CNT_W-1:0]  cnt_wdata, cnt_rd;
  logic [VAL_W-1:0]  val_wdata, val_rd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      count_mem[mem_waddr] <= cnt_wdata;
      value_mem[mem_waddr] <= val_wdata;
    end
    cnt_rd <= count_mem[mem_raddr];
    val_rd <= value_mem[mem_raddr];
  end

  // Item registers carried through the pipeline.
  in_item_t                it;
  logic signed [64:0]      prod_x, prod_y;
  logic                    ok;
  logic [COL_W-1:0]        col_q;
  logic [ROW_W-1:0]        row_q;
  logic [ADDR_W-1:0]       k_q, k_comb, clr_addr;
  out_item_t               res;

  assign k_comb = ADDR_W'(row_q * eff_w) + ADDR_W'(col_q);
  assign mem_raddr = k_comb;

  // Mapping arithmetic: offset from the origin times the reciprocal, Q32.32.
  logic signed [32:0] d_x, d_y;
  assign d_x = 33'(it.x_pos) - 33'(origin_x);
  assign d_y = 33'(it.y_pos) - 33'(origin_y);

  logic point_ok, read_ok, mode_ok;
  always_comb begin
    case (mode)
      MODE_COUNT: mode_ok = 1'b1;
      MODE_SUM, MODE_MEAN, MODE_MIN, MODE_MAX: mode_ok = !it.value_missing;
      default: mode_ok = 1'b0;
    endcase
  end
  assign point_ok = !it.coord_bad && !prod_x[64] && !prod_y[64]
                    && (prod_x[63:32] < 32'(eff_w)) && (prod_y[63:32] < 32'(eff_h))
                    && mode_ok;
  assign read_ok = (DIM_W'(it.read_row) < eff_h) && (DIM_W'(it.read_col) < eff_w);

  // Read-modify-write of one cell.
  logic signed [VAL_W-1:0] v_ext, val_s, sum_val;
  logic signed [VAL_W:0]   sum_wide;
  logic [CNT_W-1:0]        cnt_inc;
  logic [VAL_W-1:0]        val_new;

  assign v_ext    = VAL_W'(it.value);
  assign val_s    = val_rd;
  assign sum_wide = (VAL_W+1)'(val_s) + (VAL_W+1)'(v_ext);
  assign sum_val  = (sum_wide > (VAL_W+1)'(SUM_MAX)) ? SUM_MAX :
                    (sum_wide < (VAL_W+1)'(SUM_MIN)) ? SUM_MIN : sum_wide[VAL_W-1:0];
  assign cnt_inc  = (cnt_rd == '1) ? cnt_rd : cnt_rd + 1'b1;

  always_comb begin
    case (mode)
      MODE_SUM, MODE_MEAN: val_new = sum_val;
      MODE_MIN: val_new = (cnt_rd == '0 || v_ext < val_s) ? v_ext : val_s;
      MODE_MAX: val_new = (cnt_rd == '0 || v_ext > val_s) ? v_ext : val_s;
      default:  val_new = val_rd;
    endcase
  end

  assign mem_we    = (state == S_CLEAR) || (state == S_UPD && !it.kind && ok);
  assign mem_waddr = (state == S_CLEAR) ? clr_addr : k_q;
  assign cnt_wdata = (state == S_CLEAR) ? '0 : cnt_inc;
  assign val_wdata = (state == S_CLEAR) ? '0 : val_new;

  // Value of a read result: zero for points, the background for an untouched or
  // outside cell, else the count or the stored value. Mean reads of touched cells go to the divider.
  logic signed [VAL_W-1:0] read_val;
  logic                    touched, mean_div;
  assign touched  = it.kind && ok && (cnt_rd != '0);
  assign mean_div = touched && (mode == MODE_MEAN);

  always_comb begin
    if (!it.kind) read_val = '0;
    else if (!touched) read_val = background;
    else if (mode == MODE_COUNT) read_val = VAL_W'(cnt_rd);
    else read_val = val_rd;
  end

  // Mean divider: restoring, one quotient bit per cycle on magnitudes.
  logic [VAL_W-1:0] div_q, q_step;
  logic [CNT_W:0]   div_r, r_shift, r_step;
  logic [CNT_W-1:0] div_d;
  logic [5:0]       div_n;
  logic             div_neg;

  always_comb begin
    r_shift = {div_r[CNT_W-1:0], div_q[VAL_W-1]};
    if (r_shift >= {1'b0, div_d}) begin
      r_step = r_shift - {1'b0, div_d};
      q_step = {div_q[VAL_W-2:0], 1'b1};
    end else begin
      r_step = r_shift;
      q_step = {div_q[VAL_W-2:0], 1'b0};
    end
  end

  assign item_ready = (state == S_IDLE);

  // The result register loads when the finished transaction can move out.
  logic out_fire;
  assign out_fire = (state == S_OUT) && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (out_fire) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item_valid) begin
            it    <= item;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod_x <= 65'(d_x) * 65'(inv_pixel_x);
          prod_y <= 65'(d_y) * 65'(inv_pixel_y);
          state  <= S_MAP;
        end
        S_MAP: begin
          if (it.kind) begin
            ok    <= read_ok;
            col_q <= COL_W'(it.read_col);
            row_q <= ROW_W'(it.read_row);
          end else begin
            ok    <= point_ok;
            col_q <= prod_x[32 +: COL_W];
            row_q <= prod_y[32 +: ROW_W];
          end
          state <= S_ADDR;
        end
        S_ADDR: begin
          k_q   <= k_comb;
          state <= S_UPD;
        end
        S_UPD: begin
          res.point_taken  <= !it.kind && ok;
          res.cell_index   <= ok ? 16'(k_q) : 16'd0;
          res.cell_touched <= touched;
          if (mean_div) begin
            div_neg <= val_rd[VAL_W-1];
            div_q   <= val_rd[VAL_W-1] ? -val_rd : val_rd;
            div_r   <= '0;
            div_d   <= cnt_rd;
            div_n   <= '0;
            state   <= S_DIV;
          end else begin
            res.cell_value <= read_val;
            state          <= S_OUT;
          end
        end
        S_DIV: begin
          div_q <= q_step;
          div_r <= r_step;
          div_n <= div_n + 1'b1;
          if (div_n == 6'(VAL_W - 1)) begin
            res.cell_value <= div_neg ? -q_step : q_step;
            state          <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_fire) begin
            result <= res;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/ptg_checker.sv =====
// Port-level checker of the point to grid reducer and its bind statement.
`timescale 1ns / 1ps
`include "point_to_grid_reducer_macros.svh"
module ptg_checker
  import ptg_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      item_ready,
  input logic      result_valid,
  input logic      result_ready,
  input out_item_t result
);

  `PTG_ASSERT(a_result_held, result_valid && !result_ready |=> result_valid)
  `PTG_ASSERT(a_result_stable, result_valid && !result_ready |=> $stable(result))
  `PTG_ASSERT(a_point_untouched, result_valid && result.point_taken |-> !result.cell_touched)
  `PTG_ASSERT(a_point_no_value, result_valid && result.point_taken |-> result.cell_value == '0)
  `PTG_ASSERT_ALWAYS(a_clear_after_reset, $past(rst) && !rst |-> !item_ready)

endmodule

bind point_to_grid_reducer ptg_checker u_ptg_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
